// ----- hw/rtl/lzss_stream_decompressor_top_defines.svh -----
// ---------------------------------------------------------------------------
// lzss stream decompressor assertion macros
// concurrent checks that compile away when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef LZSS_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZSS_STREAM_DECOMPRESSOR_TOP_DEFINES_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define LZSD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen outside reset
`define LZSD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LZSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LZSD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/lzsd_pkg.sv -----
// ---------------------------------------------------------------------------
// lzsd_pkg
// shared constants, codes and types of the lzss stream decompressor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lzsd_pkg;

  // window memory, a power of two between 4096 and 65536 entries
  localparam int unsigned WINDOW_DEPTH = 16384;
  localparam int unsigned AW           = $clog2(WINDOW_DEPTH);

  // field widths
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned DIST_W = 14;  // offset times three
  localparam int unsigned SUB_W  = (AW > DIST_W) ? AW : DIST_W;
  localparam int unsigned CNT_W  = 6;   // up to 48 bytes per reference
  localparam int unsigned FIDX_W = 3;

  // result queue in the back end
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OPTR_W    = $clog2(OUT_DEPTH);
  localparam int unsigned OCNT_W    = OPTR_W + 1;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CQPTR_W    = $clog2(CMDQ_DEPTH);
  localparam int unsigned CQCNT_W    = CQPTR_W + 1;

  localparam logic [LEN_W-1:0] OUTPUT_LENGTH_RST = 25'd16777216;

  // configuration register indexes
  typedef enum logic {
    CFG_PIXEL_MODE    = 1'b0,
    CFG_OUTPUT_LENGTH = 1'b1
  } cfg_idx_e;

  // parser phase
  typedef enum logic [1:0] {
    PH_FLAG,
    PH_TOKEN,
    PH_REF_HI
  } phase_e;

  // back end command kinds
  typedef enum logic [1:0] {
    CMD_LIT,
    CMD_COPY,
    CMD_ERR
  } cmd_kind_e;

  typedef struct packed {
    logic             pixel_mode;
    logic [LEN_W-1:0] output_length;
  } cfg_t;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [7:0]       data;
    logic [CNT_W-1:0] cnt;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             done;     // last byte fills the output length
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       bad;
    logic       done;
  } res_t;

endpackage

// ----- hw/rtl/lzsd_front.sv -----
// ---------------------------------------------------------------------------
// lzsd_front
// token parser: takes compressed bytes, tracks flags and output count,
// and hands literal, copy and error commands to the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzsd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lzsd_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_first_i,
  input  logic            cmd_full_i,
  output logic            cmd_push_o,
  output lzsd_pkg::cmd_t  cmd_o
);
  import lzsd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [7:0]          flags_q, flags_d;
  logic [FIDX_W-1:0]   fidx_q, fidx_d;
  logic [7:0]          offlo_q, offlo_d;
  logic [1:0]          lpart_q, lpart_d;
  logic                halted_q, halted_d;
  logic [LEN_W-1:0]    bw_q, bw_d;

  phase_e              phase_cur, tok_phase;
  logic [7:0]          flags_cur, offlo_cur;
  logic [FIDX_W-1:0]   fidx_cur, tok_fidx;
  logic [1:0]          lpart_cur;
  logic                halted_cur;
  logic [LEN_W-1:0]    bw_cur, room;
  logic                accept, ignore, lit_bit, lit_ends;
  logic [15:0]         code;
  logic [OFF_W-1:0]    off;
  logic [3:0]          len;
  logic [DIST_W-1:0]   ref_dist;
  logic [CNT_W-1:0]    len1, cnt_raw, cnt_eff;
  logic                bad, done_copy;
  logic [SUB_W-1:0]    src;

  // a first byte clears the stream state before it is parsed
  assign phase_cur  = in_first_i ? PH_FLAG : phase_q;
  assign flags_cur  = in_first_i ? 8'd0 : flags_q;
  assign fidx_cur   = in_first_i ? '0 : fidx_q;
  assign offlo_cur  = in_first_i ? 8'd0 : offlo_q;
  assign lpart_cur  = in_first_i ? 2'd0 : lpart_q;
  assign halted_cur = in_first_i ? 1'b0 : halted_q;
  assign bw_cur     = in_first_i ? '0 : bw_q;

  assign accept = in_valid_i && !cmd_full_i;
  assign ignore = halted_cur || (bw_cur >= cfg_i.output_length);
  assign room   = cfg_i.output_length - bw_cur;

  // token bookkeeping after a finished token
  assign tok_fidx  = fidx_cur + FIDX_W'(1);
  assign tok_phase = (fidx_cur == '1) ? PH_FLAG : PH_TOKEN;
  assign lit_bit   = flags_cur[fidx_cur];
  assign lit_ends  = !cfg_i.pixel_mode || (lpart_cur >= 2'd2);

  // reference decode
  assign code = {in_byte_i, offlo_cur};
  assign off  = code[15:4];
  assign len  = code[3:0];
  assign ref_dist = cfg_i.pixel_mode ? (DIST_W'({off, 1'b0}) + DIST_W'(off)) : DIST_W'(off);
  assign len1 = CNT_W'(len) + CNT_W'(1);
  assign cnt_raw = cfg_i.pixel_mode ? (CNT_W'({len1, 1'b0}) + len1)
                                    : (CNT_W'(len) + CNT_W'(2));
  assign bad  = (ref_dist == '0) || (LEN_W'(ref_dist) > bw_cur);

  // copy cut short at the output length
  assign done_copy = room <= LEN_W'(cnt_raw);
  assign cnt_eff   = done_copy ? room[CNT_W-1:0] : cnt_raw;
  assign src       = bw_cur[SUB_W-1:0] - SUB_W'(ref_dist);

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = phase_cur;
      if (!ignore) begin
        case (phase_cur)
          PH_FLAG:   phase_d = PH_TOKEN;
          PH_REF_HI: if (!bad) phase_d = tok_phase;
          default: begin
            if (lit_bit) begin
              phase_d = lit_ends ? tok_phase : PH_TOKEN;
            end else begin
              phase_d = PH_REF_HI;
            end
          end
        endcase
      end
    end
  end

  // parser datapath
  always_comb begin
    flags_d  = flags_q;
    fidx_d   = fidx_q;
    offlo_d  = offlo_q;
    lpart_d  = lpart_q;
    halted_d = halted_q;
    bw_d     = bw_q;
    if (accept) begin
      flags_d  = flags_cur;
      fidx_d   = fidx_cur;
      offlo_d  = offlo_cur;
      lpart_d  = lpart_cur;
      halted_d = halted_cur;
      bw_d     = bw_cur;
      if (!ignore) begin
        case (phase_cur)
          PH_FLAG: begin
            flags_d = in_byte_i;
            fidx_d  = '0;
          end
          PH_REF_HI: begin
            if (bad) begin
              halted_d = 1'b1;
            end else begin
              bw_d   = bw_cur + LEN_W'(cnt_eff);
              fidx_d = tok_fidx;
            end
          end
          default: begin
            if (lit_bit) begin
              bw_d = bw_cur + LEN_W'(1);
              if (lit_ends) begin
                lpart_d = 2'd0;
                fidx_d  = tok_fidx;
              end else begin
                lpart_d = lpart_cur + 2'd1;
              end
            end else begin
              offlo_d = in_byte_i;
            end
          end
        endcase
      end
    end
  end

  // command to the back end
  always_comb begin
    cmd_push_o    = 1'b0;
    cmd_o.kind    = CMD_LIT;
    cmd_o.data    = in_byte_i;
    cmd_o.cnt     = CNT_W'(1);
    cmd_o.rd_addr = src[AW-1:0];
    cmd_o.wr_addr = bw_cur[AW-1:0];
    cmd_o.done    = (room == LEN_W'(1));
    if (accept && !ignore) begin
      case (phase_cur)
        PH_FLAG: cmd_push_o = 1'b0;
        PH_REF_HI: begin
          cmd_push_o = 1'b1;
          if (bad) begin
            cmd_o.kind = CMD_ERR;
            cmd_o.done = 1'b0;
          end else begin
            cmd_o.kind = CMD_COPY;
            cmd_o.cnt  = cnt_eff;
            cmd_o.done = done_copy;
          end
        end
        default: cmd_push_o = lit_bit;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FLAG;
      flags_q  <= 8'd0;
      fidx_q   <= '0;
      offlo_q  <= 8'd0;
      lpart_q  <= 2'd0;
      halted_q <= 1'b0;
      bw_q     <= '0;
    end else begin
      phase_q  <= phase_d;
      flags_q  <= flags_d;
      fidx_q   <= fidx_d;
      offlo_q  <= offlo_d;
      lpart_q  <= lpart_d;
      halted_q <= halted_d;
      bw_q     <= bw_d;
    end
  end

endmodule

// ----- hw/rtl/lzsd_cmd_queue.sv -----
// ---------------------------------------------------------------------------
// lzsd_cmd_queue
// two-entry command queue between the parser and the copy engine
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzsd_cmd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lzsd_pkg::cmd_t  cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output lzsd_pkg::cmd_t  cmd_o
);
  import lzsd_pkg::*;

  cmd_t                mem_q [CMDQ_DEPTH];
  logic [CQPTR_W-1:0]  wptr_q, rptr_q;
  logic [CQCNT_W-1:0]  cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CQCNT_W'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + CQPTR_W'(1);
      if (do_pop)  rptr_q <= rptr_q + CQPTR_W'(1);
      cnt_q <= cnt_q + CQCNT_W'(do_push) - CQCNT_W'(do_pop);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= cmd_i;
  end

endmodule

// ----- hw/rtl/lzsd_back.sv -----
// ---------------------------------------------------------------------------
// lzsd_back
// copy engine: runs commands against the window memory, one byte a cycle while the result queue has room,
// and queues the result words
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzsd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  lzsd_pkg::cmd_t  cmd_i,
  output logic            cmd_pop_o,
  output logic            empty_o,
  input  logic            pop_i,
  output lzsd_pkg::res_t  res_o
);
  import lzsd_pkg::*;

  // active command
  logic             act_valid_q;
  cmd_kind_e        act_kind_q;
  logic [7:0]       act_data_q;
  logic [AW-1:0]    act_rd_q, act_wr_q;
  logic [CNT_W-1:0] act_rem_q;
  logic             act_done_q;

  // write stage
  logic             s1_valid_q;
  cmd_kind_e        s1_kind_q;
  logic [7:0]       s1_lit_q;
  logic [AW-1:0]    s1_wr_q;
  logic             s1_last_q, s1_done_q, s1_byp_q;
  logic [7:0]       s1_data;

  // window memory and forwarding
  logic [7:0]       win_q [WINDOW_DEPTH];
  logic [7:0]       rdata_q, fwd_q;

  // result queue
  res_t             oq_q [OUT_DEPTH];
  logic [OPTR_W-1:0] owptr_q, orptr_q;
  logic [OCNT_W-1:0] ocnt_q;

  logic issue, last_issue, load, byp, opop, s1_write;

  assign issue      = act_valid_q && ((ocnt_q + OCNT_W'(s1_valid_q)) < OCNT_W'(OUT_DEPTH));
  assign last_issue = (act_rem_q == CNT_W'(1));
  assign load       = cmd_valid_i && (!act_valid_q || (issue && last_issue));
  assign cmd_pop_o  = load;

  // read of a byte written in this same cycle comes from the write stage
  assign s1_write = s1_valid_q && (s1_kind_q != CMD_ERR);
  assign byp      = s1_write && (s1_wr_q == act_rd_q);

  always_comb begin
    case (s1_kind_q)
      CMD_LIT:  s1_data = s1_lit_q;
      CMD_COPY: s1_data = s1_byp_q ? fwd_q : rdata_q;
      default:  s1_data = 8'd0;
    endcase
  end

  // active command control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (load) begin
        act_valid_q <= 1'b1;
      end else if (issue && last_issue) begin
        act_valid_q <= 1'b0;
      end
      s1_valid_q <= issue;
    end
  end

  // active command payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      act_kind_q <= cmd_i.kind;
      act_data_q <= cmd_i.data;
      act_rd_q   <= cmd_i.rd_addr;
      act_wr_q   <= cmd_i.wr_addr;
      act_rem_q  <= cmd_i.cnt;
      act_done_q <= cmd_i.done;
    end else if (issue) begin
      act_rd_q  <= act_rd_q + AW'(1);
      act_wr_q  <= act_wr_q + AW'(1);
      act_rem_q <= act_rem_q - CNT_W'(1);
    end
  end

  // write stage payload
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_kind_q <= act_kind_q;
      s1_lit_q  <= act_data_q;
      s1_wr_q   <= act_wr_q;
      s1_last_q <= last_issue;
      s1_done_q <= act_done_q && last_issue;
      s1_byp_q  <= byp;
    end
  end

  // window memory: read at issue, write at the write stage
  always_ff @(posedge clk_i) begin
    if (issue) rdata_q <= win_q[act_rd_q];
    if (s1_write) win_q[s1_wr_q] <= s1_data;
    fwd_q <= s1_data;
  end

  // result queue
  assign empty_o = (ocnt_q == '0);
  assign opop    = pop_i && !empty_o;
  assign res_o   = oq_q[orptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= '0;
      orptr_q <= '0;
      ocnt_q  <= '0;
    end else begin
      if (s1_valid_q) owptr_q <= owptr_q + OPTR_W'(1);
      if (opop)       orptr_q <= orptr_q + OPTR_W'(1);
      ocnt_q <= ocnt_q + OCNT_W'(s1_valid_q) - OCNT_W'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      oq_q[owptr_q] <= '{data: s1_data, last: s1_last_q,
                         bad: (s1_kind_q == CMD_ERR), done: s1_done_q};
    end
  end

endmodule

// ----- hw/rtl/lzss_stream_decompressor_top.sv -----
// ---------------------------------------------------------------------------
// lzss_stream_decompressor_top
// lzss decoder with 12-bit back offsets and 4-bit lengths, byte or pixel mode
// ---------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------
//  input    | push / full       | in_byte_i, in_first_i
//  result   | empty / pop       | out_byte_o, out_last_o, malformed_o, done_res_o
//  config   | cfg_we_i          | cfg_idx_i, cfg_wdata_i
//
// the parser takes one compressed byte per cycle while its two-entry command
// queue has room; flag and reference-low bytes give no result.
// the copy engine gives one result word per cycle while its result queue has
// room, limited by the single read port of the window memory. a result passes
// through the command queue, the active command, write stage and result queue.
// reset needs no clearing pass; the window holds no valid bits.
`timescale 1ns / 1ps
`include "lzss_stream_decompressor_top_defines.svh"

module lzss_stream_decompressor_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte_i,
  input  logic        in_first_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  output logic        malformed_o,
  output logic        done_res_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [lzsd_pkg::LEN_W-1:0] cfg_wdata_i
);
  import lzsd_pkg::*;

  cfg_t cfg_q;
  cmd_t fr_cmd, q_cmd;
  res_t res;
  logic fr_push, q_full, q_valid, q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_mode    <= 1'b0;
      cfg_q.output_length <= OUTPUT_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PIXEL_MODE:    cfg_q.pixel_mode    <= cfg_wdata_i[0];
        CFG_OUTPUT_LENGTH: cfg_q.output_length <= cfg_wdata_i;
        default:           cfg_q               <= cfg_q;
      endcase
    end
  end

  // token parser
  lzsd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (push),
    .in_byte_i  (in_byte_i),
    .in_first_i (in_first_i),
    .cmd_full_i (q_full),
    .cmd_push_o (fr_push),
    .cmd_o      (fr_cmd)
  );

  // command queue
  lzsd_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_push),
    .cmd_i   (fr_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // copy engine
  lzsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign full        = q_full;
  assign out_byte_o  = res.data;
  assign out_last_o  = res.last;
  assign malformed_o = res.bad;
  assign done_res_o  = res.done;

  // checks
  `LZSD_ASSERT_NEVER(a_push_into_full, clk_i, rst_ni, fr_push && q_full, "command pushed into full queue")
  `LZSD_ASSERT(a_err_is_last, clk_i, rst_ni, (!empty && malformed_o) |-> (out_last_o && (out_byte_o == 8'd0) && !done_res_o), "malformed result not a zero last word")
  `LZSD_ASSERT(a_pop_needs_cmd, clk_i, rst_ni, q_pop |-> q_valid, "command taken from empty queue")
  `LZSD_ASSERT(a_done_is_last, clk_i, rst_ni, (!empty && done_res_o) |-> out_last_o, "done word not last of its input")

endmodule

// ----- dv/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the lzss stream decompressor: a scoreboard decodes
// every accepted compressed word and checks each result word field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lzsd_pkg::*;

  localparam int unsigned RAND_WORDS   = 430;
  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct {
    logic [7:0] b;
    logic       first;
  } comp_word_t;

  // dut ports; the inputs are known from time zero
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             push        = 1'b0;
  logic             full;
  logic [7:0]       in_byte_i   = 8'h00;
  logic             in_first_i  = 1'b0;
  logic             empty;
  logic             pop         = 1'b0;
  logic [7:0]       out_byte_o;
  logic             out_last_o;
  logic             malformed_o;
  logic             done_res_o;
  logic             cfg_we_i    = 1'b0;
  logic             cfg_idx_i   = CFG_PIXEL_MODE;
  logic [LEN_W-1:0] cfg_wdata_i = '0;

  lzss_stream_decompressor_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .in_first_i  (in_first_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .malformed_o (malformed_o),
    .done_res_o  (done_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  // scoreboard copy of the decoder state and its settings
  logic             sb_pix  = 1'b0;
  logic [LEN_W-1:0] sb_olen = OUTPUT_LENGTH_RST;
  logic [7:0]       win_mem [WINDOW_DEPTH];
  logic [LEN_W-1:0] n_out   = '0;
  phase_e           ph      = PH_FLAG;
  logic [7:0]       flags   = '0;
  logic [3:0]       fidx    = '0;
  logic [7:0]       ref_lo  = '0;
  logic [1:0]       lit_cnt = '0;
  logic             stopped = 1'b0;

  comp_word_t stream_q [$];
  res_t       decoded_q [$];

  // bookkeeping
  int unsigned n_err      = 0;
  int unsigned n_queued   = 0;
  int unsigned n_acc      = 0;
  int unsigned n_res      = 0;
  int unsigned n_bad      = 0;
  int unsigned n_settings = 0;
  int unsigned n_full     = 0;
  int unsigned cycles     = 0;

  // stream generator state
  int unsigned gen_out     = 0;
  bit          gen_aligned = 1'b0;

  // driver and monitor state
  comp_word_t  cur_word;
  int unsigned gap_left   = 0;
  bit          drv_idle   = 1'b1;
  int unsigned stall_left = 0;
  bit          mon_idle   = 1'b1;
  bit          hold_req   = 1'b0;
  bit          hold_taken = 1'b0;
  int unsigned hold_left  = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    n_err++;
  endtask

  task automatic advance_token();
    fidx++;
    if (fidx >= 4'd8) begin
      fidx = '0;
      ph   = PH_FLAG;
    end else begin
      ph = PH_TOKEN;
    end
  endtask

  // decode one compressed word, queueing the result words it yields
  task automatic decode_in_byte(input logic [7:0] b, input logic first);
    logic [15:0] code;
    int unsigned ref_dist;
    int unsigned cnt;
    int unsigned src;
    res_t        r;
    if (first) begin
      n_out   = '0;
      ph      = PH_FLAG;
      flags   = '0;
      fidx    = '0;
      ref_lo  = '0;
      lit_cnt = '0;
      stopped = 1'b0;
    end
    if (stopped || n_out >= sb_olen) return;

    // flag word opens a group of eight tokens
    if (ph == PH_FLAG) begin
      flags = b;
      fidx  = '0;
      ph    = PH_TOKEN;
      return;
    end

    // reference high word completes a back copy
    if (ph == PH_REF_HI) begin
      code = {b, ref_lo};
      ref_dist = sb_pix ? 3 * 32'(code[15:4]) : 32'(code[15:4]);
      cnt  = sb_pix ? 3 * (32'(code[3:0]) + 1) : 32'(code[3:0]) + 2;
      if (ref_dist == 0 || ref_dist > 32'(n_out)) begin
        r.data = 8'h00;
        r.last = 1'b1;
        r.bad  = 1'b1;
        r.done = 1'b0;
        decoded_q.push_back(r);
        stopped = 1'b1;
        return;
      end
      for (int unsigned i = 0; i < cnt && n_out < sb_olen; i++) begin
        src = (32'(n_out) - ref_dist) % WINDOW_DEPTH;
        r.data = win_mem[src];
        win_mem[32'(n_out) % WINDOW_DEPTH] = r.data;
        n_out++;
        r.done = (n_out >= sb_olen);
        r.last = (i + 1 == cnt) || r.done;
        r.bad  = 1'b0;
        decoded_q.push_back(r);
      end
      advance_token();
      return;
    end

    // literal, or the low word of a reference
    if (flags[fidx[2:0]]) begin
      win_mem[32'(n_out) % WINDOW_DEPTH] = b;
      n_out++;
      r.data = b;
      r.last = 1'b1;
      r.bad  = 1'b0;
      r.done = (n_out >= sb_olen);
      decoded_q.push_back(r);
      if (sb_pix) begin
        lit_cnt++;
        if (lit_cnt >= 2'd3) begin
          lit_cnt = '0;
          advance_token();
        end else begin
          ph = PH_TOKEN;
        end
      end else begin
        lit_cnt = '0;
        advance_token();
      end
    end else begin
      ref_lo = b;
      ph     = PH_REF_HI;
    end
  endtask

  task automatic add_word(input logic [7:0] b, input logic first);
    comp_word_t w;
    w.b     = b;
    w.first = first;
    stream_q.push_back(w);
    n_queued++;
  endtask

  // well-formed groups of a flag word and eight tokens, now and then broken
  task automatic gen_groups(input bit fresh, input int unsigned groups);
    logic [7:0]  fl;
    logic [11:0] off;
    logic [3:0]  len;
    int unsigned unit;
    int unsigned max_off;
    int unsigned roll;
    int unsigned cut;
    unit = sb_pix ? 3 : 1;
    if (fresh) gen_out = 0;
    gen_aligned = 1'b1;
    for (int unsigned g = 0; g < groups; g++) begin
      fl = 8'($urandom_range(0, 255));
      if (gen_out < unit) fl[0] = 1'b1;
      add_word(fl, fresh && g == 0);
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
      for (int unsigned t = 0; t < 8; t++) begin
        if (t == cut) begin
          // stop mid-group; the next stream starts afresh
          if ($urandom_range(0, 1)) add_word(8'($urandom_range(0, 255)), 1'b0);
          gen_aligned = 1'b0;
          return;
        end
        if (fl[t]) begin
          for (int unsigned k = 0; k < unit; k++) add_word(8'($urandom_range(0, 255)), 1'b0);
          gen_out += unit;
        end else begin
          max_off = gen_out / unit;
          if (max_off > 4095) max_off = 4095;
          roll = $urandom_range(0, 99);
          len  = 4'($urandom_range(0, 15));
          if (roll < 3 || max_off == 0) begin
            // zero offset, or one reaching before the start
            off = (roll == 0 || max_off == 4095) ? 12'd0 : 12'(max_off + 1);
          end else if (roll < 60) begin
            off = 12'($urandom_range(1, (max_off < 8) ? max_off : 8));
          end else begin
            off = 12'($urandom_range(1, max_off));
          end
          add_word({off[3:0], len}, 1'b0);
          add_word(off[11:4], 1'b0);
          gen_out += sb_pix ? 3 * (32'(len) + 1) : 32'(len) + 2;
        end
      end
    end
  endtask

  // wait until every word went in and every result came out, plus slack
  task automatic wait_drained();
    do @(negedge clk_i); while (stream_q.size() != 0 || push || decoded_q.size() != 0);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // write both registers back to back while the block is idle
  task automatic set_config(input logic pix, input logic [LEN_W-1:0] olen);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_PIXEL_MODE;
    cfg_wdata_i <= LEN_W'(pix);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_OUTPUT_LENGTH;
    cfg_wdata_i <= olen;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb_pix  = pix;
    sb_olen = olen;
    n_settings++;
    @(negedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin : drv
    bit offer;
    offer = push;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && full) n_full++;
      if (push && !full) begin
        decode_in_byte(cur_word.b, cur_word.first);
        n_acc++;
        offer    = 1'b0;
        gap_left = drv_idle ? $urandom_range(0, 4) : 0;
        if ($urandom_range(0, 39) == 0) drv_idle = !drv_idle;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_q.size() > 0) begin
          cur_word   = stream_q.pop_front();
          offer      = 1'b1;
          in_byte_i  <= cur_word.b;
          in_first_i <= cur_word.first;
        end
      end
      push <= offer;
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : mon
    res_t w;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_res++;
        if (malformed_o) n_bad++;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("result word 0x%02h with nothing expected", out_byte_o));
        end else begin
          w = decoded_q.pop_front();
          if (out_byte_o !== w.data)
            report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h", out_byte_o, w.data));
          if (out_last_o !== w.last)
            report_mismatch($sformatf("out_last %b, expected %b", out_last_o, w.last));
          if (malformed_o !== w.bad)
            report_mismatch($sformatf("malformed %b, expected %b", malformed_o, w.bad));
          if (done_res_o !== w.done)
            report_mismatch($sformatf("done_res %b, expected %b", done_res_o, w.done));
        end
        stall_left = mon_idle ? $urandom_range(0, 4) : 0;
        if ($urandom_range(0, 39) == 0) mon_idle = !mon_idle;
      end
      if (hold_left != 0) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin : stim
    int unsigned dir_words;
    int unsigned phase_no;
    int unsigned pick;
    logic [LEN_W-1:0] olen;
    bit fresh;
    foreach (win_mem[i]) win_mem[i] = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // byte mode at reset settings: literals at both extremes, an
    // overlapping copy, a zero offset, a word after the halt, and a
    // reference before the start of a fresh stream
    add_word(8'hF3, 1'b1);
    add_word(8'h00, 1'b0);
    add_word(8'hFF, 1'b0);
    add_word(8'h1F, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'hAA, 1'b0);
    add_word(8'h00, 1'b1);
    add_word(8'h50, 1'b0);
    add_word(8'h00, 1'b0);
    wait_drained();

    // zero output length ignores even the flag word
    set_config(1'b1, '0);
    add_word(8'h55, 1'b1);
    add_word(8'h01, 1'b0);
    wait_drained();

    // pixel mode, longest copy cut short by the output length
    set_config(1'b1, LEN_W'(20));
    add_word(8'hFD, 1'b1);
    add_word(8'h12, 1'b0);
    add_word(8'h34, 1'b0);
    add_word(8'h56, 1'b0);
    add_word(8'h1F, 1'b0);
    add_word(8'h00, 1'b0);
    add_word(8'h77, 1'b0);
    wait_drained();
    dir_words = n_queued;

    // random phases, each with settings of its own
    phase_no = 0;
    while (n_queued - dir_words < RAND_WORDS) begin
      wait_drained();
      pick = $urandom_range(0, 9);
      case (pick)
        0:       olen = '0;
        1:       olen = LEN_W'(1);
        2, 3, 4: olen = LEN_W'($urandom_range(2, 300));
        5:       olen = OUTPUT_LENGTH_RST;
        6:       olen = OUTPUT_LENGTH_RST - 1;
        default: olen = LEN_W'($urandom_range(301, 16777216));
      endcase
      // the hold-off phase needs a fresh stream with plenty of output
      if (phase_no == 1) olen = OUTPUT_LENGTH_RST;
      set_config(1'($urandom_range(0, 1)), olen);
      if (phase_no == 1) hold_req = 1'b1;
      fresh = (phase_no == 1) || !gen_aligned || ($urandom_range(0, 3) != 0);
      gen_groups(fresh, $urandom_range(2, 5));
      if ($urandom_range(0, 1)) gen_groups(!gen_aligned || $urandom_range(0, 1), $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) begin
        // noise words with stray stream starts
        repeat ($urandom_range(3, 10))
          add_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        gen_aligned = 1'b0;
      end
      phase_no++;
    end
    wait_drained();

    $display("covered %0d compressed words over %0d register settings, %0d result words checked",
             n_acc, n_settings, n_res);
    $display("%0d error results, input held back by a full block on %0d cycles", n_bad, n_full);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_front.sv
hw/rtl/lzsd_cmd_queue.sv
hw/rtl/lzsd_back.sv
hw/rtl/lzss_stream_decompressor_top.sv
dv/tb.sv
